### hw/rtl/cpts_pkg.sv
// Shared types, constants and helper functions for the cyclic priority task scheduler.
`default_nettype none

package cpts_pkg;

   // Task count limits and per-task period mask layout
   localparam int DEFAULT_TASK_COUNT = 8;
   localparam int MAX_TASKS          = 16;
   localparam int MAX_TASK_IDX_WIDTH = 4;
   localparam int PERIOD_BITS        = 3;
   localparam int MASKED_TASKS       = 8;
   localparam int TASK_FIELD_WIDTH   = 3;
   localparam int RESTART_WIDTH      = 8;

   // Tick count and the mod-100 residue that is built from it, one nibble a step
   localparam int MS_WIDTH    = 32;
   localparam int DIGIT_WIDTH = 4;
   localparam int MS_DIGITS   = MS_WIDTH / DIGIT_WIDTH;
   localparam int DIGIT_CNT_WIDTH = $clog2(MS_DIGITS);
   localparam int TICK_MOD    = 100;
   localparam int RES_WIDTH   = 7;
   localparam int ACC_WIDTH   = RES_WIDTH + DIGIT_WIDTH;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 24;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ENABLE  = 1'b0,
      CSR_PERIODS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_READY     = 2'd0,
      ST_ACTIVE    = 2'd1,
      ST_SUSPENDED = 2'd2,
      ST_COMPLETE  = 2'd3
   } task_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIVIDE,
      S_RESTART,
      S_SELECT,
      S_EMIT
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic shift;
      logic restart;
      logic select;
      logic emit;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_digit;
   } dp_status_type;

   // One residue step: (16*r + d) mod 100, with r < 100 on entry
   function automatic logic [RES_WIDTH-1:0] mod100_step(
      input logic [RES_WIDTH-1:0]   r,
      input logic [DIGIT_WIDTH-1:0] d
   );
      logic [ACC_WIDTH-1:0] v;
      v = {r, {DIGIT_WIDTH{1'b0}}} + ACC_WIDTH'(d);
      if (v >= ACC_WIDTH'(8 * TICK_MOD)) v = v - ACC_WIDTH'(8 * TICK_MOD);
      if (v >= ACC_WIDTH'(4 * TICK_MOD)) v = v - ACC_WIDTH'(4 * TICK_MOD);
      if (v >= ACC_WIDTH'(2 * TICK_MOD)) v = v - ACC_WIDTH'(2 * TICK_MOD);
      if (v >= ACC_WIDTH'(TICK_MOD))     v = v - ACC_WIDTH'(TICK_MOD);
      return v[RES_WIDTH-1:0];
   endfunction

   // Trigger flags from the mod-100 residue: bit0 10 ms, bit1 50 ms, bit2 100 ms
   function automatic logic [PERIOD_BITS-1:0] triggers_of(input logic [RES_WIDTH-1:0] r);
      logic t10;
      logic t50;
      logic t100;
      t10 = 1'b0;
      for (int k = 0; k < TICK_MOD / 10; k++) begin
         if (r == RES_WIDTH'(10 * k)) t10 = 1'b1;
      end
      t50  = (r == '0) || (r == RES_WIDTH'(TICK_MOD / 2));
      t100 = (r == '0);
      return {t100, t50, t10};
   endfunction

   // Index of the lowest set bit (0 when none is set)
   function automatic logic [MAX_TASK_IDX_WIDTH-1:0] first_set(input logic [MAX_TASKS-1:0] v);
      logic [MAX_TASK_IDX_WIDTH-1:0] idx;
      idx = '0;
      for (int i = MAX_TASKS - 1; i >= 0; i--) begin
         if (v[i]) idx = MAX_TASK_IDX_WIDTH'(i);
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/cpts_ctrl.sv
// Sequencing state machine: tick residue, restart pass, selection, response.
`default_nettype none

module cpts_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output cpts_pkg::dp_cmd_type        cmd,
   input  wire cpts_pkg::dp_status_type stat
);

   cpts_pkg::ctrl_state_type state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_free;

   // The response register can take a new result when empty or being drained
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cpts_pkg::S_IDLE:    if (req_valid) state_in = cpts_pkg::S_DIVIDE;
         cpts_pkg::S_DIVIDE:  if (stat.last_digit) state_in = cpts_pkg::S_RESTART;
         cpts_pkg::S_RESTART: state_in = cpts_pkg::S_SELECT;
         cpts_pkg::S_SELECT:  state_in = cpts_pkg::S_EMIT;
         cpts_pkg::S_EMIT:    if (rsp_free) state_in = cpts_pkg::S_IDLE;
         default:             state_in = cpts_pkg::S_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         cpts_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         cpts_pkg::S_DIVIDE:  cmd.shift   = 1'b1;
         cpts_pkg::S_RESTART: cmd.restart = 1'b1;
         cpts_pkg::S_SELECT:  cmd.select  = 1'b1;
         cpts_pkg::S_EMIT:    cmd.emit    = rsp_free;
         default:             cmd         = '0;
      endcase
   end

   // Response valid: set when the response register is loaded, held while stalled
   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpts_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/cpts_dp.sv
// Datapath: config registers, tick residue, task status table and selection logic.
`default_nettype none

module cpts_dp #(
   parameter int TASK_COUNT = cpts_pkg::DEFAULT_TASK_COUNT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire cpts_pkg::dp_cmd_type                    cmd,
   output cpts_pkg::dp_status_type                      stat,
   input  wire logic                                    csr_we,
   input  wire logic [cpts_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [cpts_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,
   input  wire logic [cpts_pkg::MS_WIDTH-1:0]           req_elapsed_ms,
   input  wire logic                                    req_running_done,
   output logic                                         rsp_switch_request,
   output logic [cpts_pkg::TASK_FIELD_WIDTH-1:0]        rsp_from_task,
   output logic [cpts_pkg::TASK_FIELD_WIDTH-1:0]        rsp_to_task,
   output logic [cpts_pkg::RESTART_WIDTH-1:0]           rsp_restarted_mask,
   output logic [cpts_pkg::PERIOD_BITS-1:0]             rsp_period_triggers
);

   localparam int IDXW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

   // Configuration
   logic                                  en_ff;
   logic [cpts_pkg::CSR_DATA_WIDTH-1:0]   masks_ff;

   // Request capture and residue
   logic [cpts_pkg::MS_WIDTH-1:0]         ms_ff;
   logic                                  done_ff;
   logic [cpts_pkg::RES_WIDTH-1:0]        res_ff;
   logic [cpts_pkg::DIGIT_CNT_WIDTH-1:0]  dig_ff;

   // Scheduler state
   cpts_pkg::task_status_type             status_ff [TASK_COUNT];
   cpts_pkg::task_status_type             status_rst_in [TASK_COUNT];
   cpts_pkg::task_status_type             status_sel_in [TASK_COUNT];
   logic [IDXW-1:0]                       run_ff;

   // Result staging
   logic [cpts_pkg::PERIOD_BITS-1:0]      trig_ff;
   logic [TASK_COUNT-1:0]                 restarted_ff;
   logic                                  sw_ff;
   logic [IDXW-1:0]                       from_ff;
   logic [IDXW-1:0]                       to_ff;

   // Response register
   logic                                  rsp_sw_ff;
   logic [cpts_pkg::TASK_FIELD_WIDTH-1:0] rsp_from_ff;
   logic [cpts_pkg::TASK_FIELD_WIDTH-1:0] rsp_to_ff;
   logic [cpts_pkg::RESTART_WIDTH-1:0]    rsp_restarted_ff;
   logic [cpts_pkg::PERIOD_BITS-1:0]      rsp_trig_ff;

   logic [cpts_pkg::PERIOD_BITS-1:0]      pmask [TASK_COUNT];
   logic [cpts_pkg::PERIOD_BITS-1:0]      trig_now;
   logic [TASK_COUNT-1:0]                 cur_oh;
   logic [TASK_COUNT-1:0]                 restart_hit;
   logic [TASK_COUNT-1:0]                 runnable;
   logic [TASK_COUNT-1:0]                 complete;
   logic [TASK_COUNT-1:0]                 below;
   logic [TASK_COUNT-1:0]                 cand_hi;
   logic [TASK_COUNT-1:0]                 cand_lo;
   logic                                  cur_complete;
   logic                                  preempt;
   logic                                  sw_sel;
   logic [IDXW-1:0]                       next_sel;

   assign stat.last_digit = (dig_ff == cpts_pkg::DIGIT_CNT_WIDTH'(cpts_pkg::MS_DIGITS - 1));

   // Per-task period mask; tasks past the eighth have none
   for (genvar g = 0; g < TASK_COUNT; g++) begin : g_mask
      if (g < cpts_pkg::MASKED_TASKS) begin : g_on
         assign pmask[g] = masks_ff[cpts_pkg::PERIOD_BITS*g +: cpts_pkg::PERIOD_BITS];
      end else begin : g_off
         assign pmask[g] = '0;
      end
   end

   assign trig_now = cpts_pkg::triggers_of(res_ff);

   // Completion of the running task, then periodic restarts
   always_comb begin
      for (int x = 0; x < TASK_COUNT; x++) begin
         cur_oh[x]        = (run_ff == IDXW'(x));
         restart_hit[x]   = en_ff && !cur_oh[x] && ((pmask[x] & trig_now) != '0) &&
                            (status_ff[x] == cpts_pkg::ST_COMPLETE);
         status_rst_in[x] = status_ff[x];
         if (en_ff && cur_oh[x] && done_ff) status_rst_in[x] = cpts_pkg::ST_COMPLETE;
         if (restart_hit[x]) status_rst_in[x] = cpts_pkg::ST_READY;
      end
   end

   // Candidate sets for preemption and for moving on after completion
   always_comb begin
      for (int x = 0; x < TASK_COUNT; x++) begin
         runnable[x] = (status_ff[x] == cpts_pkg::ST_READY) ||
                       (status_ff[x] == cpts_pkg::ST_SUSPENDED);
         complete[x] = (status_ff[x] == cpts_pkg::ST_COMPLETE);
         below[x]    = (IDXW'(x) < run_ff);
      end
   end

   assign cand_hi      = runnable & below;
   assign cand_lo      = runnable & ~below;
   assign cur_complete = |(cur_oh & complete);
   assign preempt      = |cand_hi;
   assign sw_sel       = en_ff && (preempt || (cur_complete && (|cand_lo)));
   assign next_sel     = preempt ?
      IDXW'(cpts_pkg::first_set(cpts_pkg::MAX_TASKS'(cand_hi))) :
      IDXW'(cpts_pkg::first_set(cpts_pkg::MAX_TASKS'(cand_lo)));

   // Status after selection
   always_comb begin
      for (int x = 0; x < TASK_COUNT; x++) begin
         status_sel_in[x] = status_ff[x];
         if (sw_sel && preempt && cur_oh[x]) status_sel_in[x] = cpts_pkg::ST_SUSPENDED;
         if (sw_sel && (next_sel == IDXW'(x))) status_sel_in[x] = cpts_pkg::ST_ACTIVE;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff    <= 1'b0;
         masks_ff <= '0;
      end else if (csr_we) begin
         unique case (cpts_pkg::csr_index_type'(csr_index))
            cpts_pkg::CSR_ENABLE:  en_ff    <= csr_wdata[0];
            cpts_pkg::CSR_PERIODS: masks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Scheduler state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= IDXW'(TASK_COUNT - 1);
         for (int x = 0; x < TASK_COUNT; x++) status_ff[x] <= cpts_pkg::ST_READY;
      end else if (cmd.restart) begin
         status_ff <= status_rst_in;
      end else if (cmd.select) begin
         status_ff <= status_sel_in;
         if (sw_sel) run_ff <= next_sel;
      end
   end

   // Request capture, residue steps and result staging
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ms_ff   <= req_elapsed_ms;
         done_ff <= req_running_done;
         res_ff  <= '0;
         dig_ff  <= '0;
      end
      if (cmd.shift) begin
         ms_ff  <= ms_ff << cpts_pkg::DIGIT_WIDTH;
         res_ff <= cpts_pkg::mod100_step(res_ff,
                      ms_ff[cpts_pkg::MS_WIDTH-1 -: cpts_pkg::DIGIT_WIDTH]);
         dig_ff <= dig_ff + 1'b1;
      end
      if (cmd.restart) begin
         restarted_ff <= restart_hit;
         trig_ff      <= en_ff ? trig_now : '0;
      end
      if (cmd.select) begin
         sw_ff   <= sw_sel;
         from_ff <= run_ff;
         to_ff   <= sw_sel ? next_sel : run_ff;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_sw_ff        <= sw_ff;
         rsp_from_ff      <= cpts_pkg::TASK_FIELD_WIDTH'(from_ff);
         rsp_to_ff        <= cpts_pkg::TASK_FIELD_WIDTH'(to_ff);
         rsp_restarted_ff <= cpts_pkg::RESTART_WIDTH'(restarted_ff);
         rsp_trig_ff      <= trig_ff;
      end
   end

   assign rsp_switch_request  = rsp_sw_ff;
   assign rsp_from_task       = rsp_from_ff;
   assign rsp_to_task         = rsp_to_ff;
   assign rsp_restarted_mask  = rsp_restarted_ff;
   assign rsp_period_triggers = rsp_trig_ff;

endmodule

`default_nettype wire

### hw/rtl/cyclic_priority_task_scheduler.sv
// Top level of the cyclic priority task scheduler: controller plus datapath.
`default_nettype none

// One request per millisecond tick; each request yields exactly one response.
// A request runs from acceptance to a loaded response in steps: the 32-bit
// tick count is reduced mod 100 one nibble per cycle, then comes the
// completion/periodic-restart pass, then priority selection, and then the
// response register is loaded. The next request is taken in the cycle after
// that, so a new request is not accepted before the last one is through. A
// waiting response does not stop the next request from being accepted; it
// only holds the block at the final load.
// Task 0 has the highest priority. Tasks past the eighth have no period mask
// and no restart bit, and task numbers in the response are the low 3 bits.
// The user makes configuration writes (enable at index 0, period masks at
// index 1) only while no request is in flight; the block does not check it.
module cyclic_priority_task_scheduler #(
   parameter int TASK_COUNT = cpts_pkg::DEFAULT_TASK_COUNT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [cpts_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [cpts_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [cpts_pkg::MS_WIDTH-1:0]        req_elapsed_ms,
   input  wire logic                                 req_running_done,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_switch_request,
   output logic [cpts_pkg::TASK_FIELD_WIDTH-1:0]     rsp_from_task,
   output logic [cpts_pkg::TASK_FIELD_WIDTH-1:0]     rsp_to_task,
   output logic [cpts_pkg::RESTART_WIDTH-1:0]        rsp_restarted_mask,
   output logic [cpts_pkg::PERIOD_BITS-1:0]          rsp_period_triggers
);

   cpts_pkg::dp_cmd_type    cmd;
   cpts_pkg::dp_status_type stat;

   cpts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   cpts_dp #(
      .TASK_COUNT (TASK_COUNT)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_elapsed_ms      (req_elapsed_ms),
      .req_running_done    (req_running_done),
      .rsp_switch_request  (rsp_switch_request),
      .rsp_from_task       (rsp_from_task),
      .rsp_to_task         (rsp_to_task),
      .rsp_restarted_mask  (rsp_restarted_mask),
      .rsp_period_triggers (rsp_period_triggers)
   );

   // At most one datapath command per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.shift, cmd.restart, cmd.select, cmd.emit}))
      else $error("more than one datapath command active");

   // Selection always follows the restart pass
   assert property (@(posedge clock) disable iff (reset)
      cmd.restart |=> cmd.select)
      else $error("restart pass not followed by selection");

   // An accepted request blocks further requests while it is worked on
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is in flight");

   // No switch means the running task stays the same
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_switch_request) |-> (rsp_from_task == rsp_to_task))
      else $error("task changed without a switch");

   // A switch moves to a different task (checked only for up to eight tasks)
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_switch_request) |->
         ((TASK_COUNT > cpts_pkg::MASKED_TASKS) || (rsp_from_task != rsp_to_task)))
      else $error("switch to the task already running");

endmodule

`default_nettype wire

### tb/tb_cyclic_priority_task_scheduler.sv
// Testbench for the cyclic priority task scheduler: directed and random ticks.
`default_nettype none

module tb_cyclic_priority_task_scheduler;
   import cpts_pkg::*;

   localparam int NUM_TASKS    = DEFAULT_TASK_COUNT;
   localparam int QUIET_CYCLES = 20;  // a bit more than the time one request takes
   localparam int SEGMENT_LEN  = 60;  // requests between configuration changes

   // One scheduling response as the block reports it
   typedef struct packed {
      logic                        switch_request;
      logic [TASK_FIELD_WIDTH-1:0] from_task;
      logic [TASK_FIELD_WIDTH-1:0] to_task;
      logic [RESTART_WIDTH-1:0]    restarted_mask;
      logic [PERIOD_BITS-1:0]      period_triggers;
   } sched_result_type;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        csr_we;
   csr_index_type               csr_index;
   logic [CSR_DATA_WIDTH-1:0]   csr_wdata;
   logic                        req_valid;
   logic                        req_stall;
   logic [MS_WIDTH-1:0]         req_elapsed_ms;
   logic                        req_running_done;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_switch_request;
   logic [TASK_FIELD_WIDTH-1:0] rsp_from_task;
   logic [TASK_FIELD_WIDTH-1:0] rsp_to_task;
   logic [RESTART_WIDTH-1:0]    rsp_restarted_mask;
   logic [PERIOD_BITS-1:0]      rsp_period_triggers;

   // Scheduler state as predicted by the testbench
   task_status_type             sched_status [NUM_TASKS];
   int unsigned                 sched_running;
   logic                        sched_enable;
   logic [CSR_DATA_WIDTH-1:0]   sched_periods;

   sched_result_type            pending_results [$];
   int unsigned                 mismatch_count;
   int unsigned                 sender_gap_pct;
   int unsigned                 receiver_stall_pct;
   logic [MS_WIDTH-1:0]         tick_now;

   cyclic_priority_task_scheduler dut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_elapsed_ms      (req_elapsed_ms),
      .req_running_done    (req_running_done),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_switch_request  (rsp_switch_request),
      .rsp_from_task       (rsp_from_task),
      .rsp_to_task         (rsp_to_task),
      .rsp_restarted_mask  (rsp_restarted_mask),
      .rsp_period_triggers (rsp_period_triggers)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Random backpressure on the response side
   always @(negedge clock) begin
      rsp_stall = (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
   end

   // Apply one tick to the predicted state and return the response it should give
   function automatic sched_result_type schedule_tick(input logic [MS_WIDTH-1:0] ms,
                                                      input logic done);
      sched_result_type   res;
      int unsigned        cur;
      int unsigned        nxt;
      logic               sw;
      logic [2:0]         trig;
      logic [2:0]         pmask;
      logic [7:0]         restarted;
      cur       = sched_running;
      nxt       = cur;
      sw        = 1'b0;
      trig      = '0;
      restarted = '0;
      if (sched_enable) begin
         if (done) sched_status[cur] = ST_COMPLETE;
         trig[0] = (ms % 32'd10) == 32'd0;
         trig[1] = trig[0] && ((ms % 32'd50) == 32'd0);
         trig[2] = trig[0] && ((ms % 32'd100) == 32'd0);
         // periodic restart of completed tasks other than the running one
         for (int x = 0; x < NUM_TASKS; x++) begin
            pmask = (x < MASKED_TASKS) ? 3'((sched_periods >> (3 * x)) & 24'd7) : 3'd0;
            if (x != cur && (pmask & trig) != 0 && sched_status[x] == ST_COMPLETE) begin
               sched_status[x] = ST_READY;
               if (x < MASKED_TASKS) restarted[x] = 1'b1;
            end
         end
         // higher priority runnable task preempts
         for (int x = 0; x < cur; x++) begin
            if (!sw && (sched_status[x] == ST_READY || sched_status[x] == ST_SUSPENDED)) begin
               sched_status[cur] = ST_SUSPENDED;
               nxt = x;
               sw  = 1'b1;
            end
         end
         // otherwise a completed task hands over to the next runnable one
         if (!sw && sched_status[cur] == ST_COMPLETE) begin
            for (int x = cur; x < NUM_TASKS; x++) begin
               if (!sw && (sched_status[x] == ST_READY || sched_status[x] == ST_SUSPENDED)) begin
                  nxt = x;
                  sw  = 1'b1;
               end
            end
         end
         if (sw) begin
            sched_status[nxt] = ST_ACTIVE;
            sched_running     = nxt;
         end
      end
      res.switch_request  = sw;
      res.from_task       = 3'(cur);
      res.to_task         = 3'(nxt);
      res.restarted_mask  = restarted;
      res.period_triggers = trig;
      return res;
   endfunction

   // Response checker
   always @(posedge clock) begin
      sched_result_type got;
      sched_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_switch_request, rsp_from_task, rsp_to_task,
                 rsp_restarted_mask, rsp_period_triggers};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: sw=%0d from=%0d to=%0d restarted=%02h trig=%0d",
                        got.switch_request, got.from_task, got.to_task,
                        got.restarted_mask, got.period_triggers);
         end else begin
            want = pending_results.pop_front();
            if (got != want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response mismatch: expected sw=%0d from=%0d to=%0d restarted=%02h %s%0d, %s",
                           want.switch_request, want.from_task, want.to_task,
                           want.restarted_mask, "trig=", want.period_triggers,
                           $sformatf("got sw=%0d from=%0d to=%0d restarted=%02h trig=%0d",
                                     got.switch_request, got.from_task, got.to_task,
                                     got.restarted_mask, got.period_triggers));
            end
         end
      end
   end

   // Send one tick request, with an optional idle gap first
   task automatic send_tick(input logic [MS_WIDTH-1:0] ms, input logic done);
      int unsigned gap;
      if (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
         gap = $urandom_range(1, 14);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        = 1'b1;
      req_elapsed_ms   = ms;
      req_running_done = done;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(schedule_tick(ms, done));
   endtask

   // Stop sending and wait until every expected response has arrived
   task automatic wait_quiet();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] data);
      wait_quiet();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_ENABLE) sched_enable = data[0];
      else sched_periods = data;
   endtask

   // Next tick value: mostly a running clock, sometimes period boundaries or anything
   function automatic logic [MS_WIDTH-1:0] pick_tick();
      case ($urandom_range(9))
         6:       return 32'($urandom_range(0, 429496729)) * 32'd10;
         7:       return 32'($urandom_range(0, 85899345)) * 32'd50;
         8:       return 32'($urandom_range(0, 42949672)) * 32'd100;
         9:       return $urandom;
         default: begin
            tick_now = tick_now + 32'($urandom_range(1, 10));
            return tick_now;
         end
      endcase
   endfunction

   // Disabled block: ticks and completions change nothing
   task automatic test_disabled();
      write_csr(CSR_PERIODS, 24'hFFFFFF);
      send_tick(32'd0, 1'b1);
      send_tick(32'd100, 1'b0);
      send_tick(32'hFFFF_FFFF, 1'b1);
      send_tick(32'd55, 1'b1);
   endtask

   // Directed walk through preemption, hand-over and restarts
   task automatic test_directed_schedule();
      write_csr(CSR_ENABLE, 24'd1);
      send_tick(32'd5, 1'b0);            // task 0 preempts the last task
      send_tick(32'd10, 1'b1);           // task 0 done, hand over to task 1
      send_tick(32'd15, 1'b1);
      send_tick(32'd50, 1'b1);           // restarts preempt a completed running task
      send_tick(32'd100, 1'b0);
      send_tick(32'd0, 1'b1);            // tick zero raises every trigger
      send_tick(32'hFFFF_FFFF, 1'b1);
      send_tick(32'd4294967290, 1'b0);   // 10 ms boundary near the top of the range
      for (int k = 0; k < 9; k++) send_tick(32'(1001 + 2 * k), 1'b1);
      send_tick(32'd4294967200, 1'b1);   // all restart, preempt
      write_csr(CSR_PERIODS, 24'd0);
      send_tick(32'd200, 1'b1);
      send_tick(32'd250, 1'b1);
      send_tick(32'd300, 1'b1);
   endtask

   task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned stall_pct,
                                      input int unsigned count);
      sender_gap_pct     = gap_pct;
      receiver_stall_pct = stall_pct;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % SEGMENT_LEN == 0) begin
            case ($urandom_range(3))
               0:       write_csr(CSR_PERIODS, 24'd0);
               1:       write_csr(CSR_PERIODS, 24'hFFFFFF);
               default: write_csr(CSR_PERIODS, 24'($urandom));
            endcase
            write_csr(CSR_ENABLE, ($urandom_range(9) != 0) ? 24'd1 : 24'd0);
         end
         // hold off until the pipeline drains, once per phase
         if (i == count / 2 + 7) wait_quiet();
         send_tick(pick_tick(), $urandom_range(99) < 35);
      end
   endtask

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_ENABLE;
      csr_wdata          = '0;
      req_valid          = 1'b0;
      req_elapsed_ms     = '0;
      req_running_done   = 1'b0;
      mismatch_count     = 0;
      sender_gap_pct     = 0;
      receiver_stall_pct = 0;
      tick_now           = '0;
      sched_enable       = 1'b0;
      sched_periods      = '0;
      sched_running      = NUM_TASKS - 1;
      foreach (sched_status[i]) sched_status[i] = ST_READY;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_disabled();
      test_directed_schedule();
      test_random_traffic(22, 62, 470);
      test_random_traffic(62, 22, 470);
      test_random_traffic(0, 0, 460);
      wait_quiet();

      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("[cyclic_priority_task_scheduler] OK");
      end else begin
         $display("[cyclic_priority_task_scheduler] ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4000000;
      $display("[cyclic_priority_task_scheduler] ERROR");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
hw/rtl/cpts_pkg.sv
hw/rtl/cpts_ctrl.sv
hw/rtl/cpts_dp.sv
hw/rtl/cyclic_priority_task_scheduler.sv
tb/tb_cyclic_priority_task_scheduler.sv
